// ===== rtl/core/chm_pkg.sv =====
// Package for the convex hull edge test marker.
// Holds item structs, controller states, datapath command and status types.
// No dependencies.
package chm_pkg;

    // fixed field widths of the item ports and of the widened coordinate
    localparam int IN_BITS   = 16;
    localparam int IDX_BITS  = 6;
    localparam int WIDE_BITS = 32;

    // parameter defaults
    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 16;

    // smallest set that has a hull
    localparam int MIN_POINTS = 3;

    // cycles between the last point issue and the side flags being final
    localparam int DRAIN_CYCLES = 3;

    typedef struct packed {
        logic signed [IN_BITS-1:0] coord_x;
        logic signed [IN_BITS-1:0] coord_y;
        logic                      final_point;
    } t_in_item;

    typedef struct packed {
        logic [IDX_BITS-1:0] hull_index;
        logic                run_end;
        logic                too_few;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_I,
        ST_RD_J,
        ST_LOAD_D,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FLUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic wr_en;    // store the incoming point
        logic cap_pi;   // latch the pivot point i
        logic cap_d;    // latch edge vector and clear side flags
        logic issue_k;  // address this cycle selects a point to test
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic left;
        logic right;
    } t_dp_stat;

endpackage

// ===== rtl/core/chm_dpath.sv =====
// Datapath of the hull marker: point memory, edge vector registers and
// the pipelined cross product side test. Depends on chm_pkg.
module chm_dpath
    import chm_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_in_item      i_item,
    input  t_dp_cmd       i_cmd,
    input  logic [AW-1:0] i_addr,
    output t_dp_stat      o_stat
);

    localparam int CW   = COORD_BITS;
    localparam int PADW = WIDE_BITS - IN_BITS;

    logic [2*CW-1:0] r_mem [MAX_POINTS];
    logic [2*CW-1:0] r_rd;

    logic [WIDE_BITS-1:0] wide_x;
    logic [WIDE_BITS-1:0] wide_y;

    logic signed [CW-1:0] rd_x;
    logic signed [CW-1:0] rd_y;
    logic signed [CW-1:0] r_pix;
    logic signed [CW-1:0] r_piy;
    logic signed [CW:0]   n_dx;
    logic signed [CW:0]   n_dy;
    logic signed [CW:0]   r_dx;
    logic signed [CW:0]   r_dy;
    logic signed [CW:0]   r_qx;
    logic signed [CW:0]   r_qy;
    logic signed [2*CW+1:0] r_lhs;
    logic signed [2*CW+1:0] r_rhs;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_left;
    logic r_right;

    // take the low coordinate bits of the item
    assign wide_x = {{PADW{1'b0}}, i_item.coord_x};
    assign wide_y = {{PADW{1'b0}}, i_item.coord_y};

    // store a point and read one point per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_addr] <= {wide_y[CW-1:0], wide_x[CW-1:0]};
        end
        r_rd <= r_mem[i_addr];
    end

    assign rd_x = $signed(r_rd[CW-1:0]);
    assign rd_y = $signed(r_rd[2*CW-1:CW]);

    // edge vector from pivot to the point just read
    assign n_dx = {rd_x[CW-1], rd_x} - {r_pix[CW-1], r_pix};
    assign n_dy = {rd_y[CW-1], rd_y} - {r_piy[CW-1], r_piy};

    // hold pivot and edge vector, run offset and product stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_pi) begin
            r_pix <= rd_x;
            r_piy <= rd_y;
        end
        if (i_cmd.cap_d) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        r_qx  <= n_dx;
        r_qy  <= n_dy;
        r_lhs <= r_dy * r_qx;
        r_rhs <= r_dx * r_qy;
    end

    // track stage valid bits and accumulate the side flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_left  <= 1'b0;
            r_right <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue_k;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.cap_d) begin
                r_left  <= 1'b0;
                r_right <= 1'b0;
            end else if (r_v3) begin
                if (r_lhs < r_rhs) begin
                    r_left <= 1'b1;
                end
                if (r_lhs > r_rhs) begin
                    r_right <= 1'b1;
                end
            end
        end
    end

    assign o_stat.left  = r_left;
    assign o_stat.right = r_right;

endmodule

// ===== rtl/core/chm_ctrl.sv =====
// Controller of the hull marker: load counting, pair and point sequencing,
// result emission. Depends on chm_pkg.
module chm_ctrl
    import chm_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_final,
    output logic          o_busy,
    output t_dp_cmd       o_cmd,
    output logic [AW-1:0] o_addr,
    input  t_dp_stat      i_stat,
    output logic          o_strobe,
    output t_out_item     o_result
);

    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int DRW  = $clog2(DRAIN_CYCLES);

    t_state r_state, n_state;
    logic [CNTW-1:0] r_count, n_count;
    logic [CNTW-1:0] r_n, n_n;
    logic [CNTW-1:0] r_i, n_i;
    logic [CNTW-1:0] r_j, n_j;
    logic [CNTW-1:0] r_k, n_k;
    logic [DRW-1:0]  r_drain, n_drain;
    logic            r_have, n_have;
    logic [IDX_BITS-1:0] r_pend, n_pend;
    logic            r_strobe, n_strobe;
    t_out_item       r_result, n_result;

    logic            accept;
    logic            room;
    logic [CNTW-1:0] count_after;
    logic [CNTW:0]   j_inc;
    logic [CNTW:0]   j_next;
    logic            j_done;
    logic            i_last;
    logic            pair_ok;

    assign accept      = i_start && (r_state == ST_IDLE);
    assign room        = r_count < CNTW'(MAX_POINTS);
    assign count_after = room ? r_count + 1'b1 : r_count;

    // next partner index, stepping over the pivot itself
    assign j_inc   = {1'b0, r_j} + 1'b1;
    assign j_next  = (j_inc == {1'b0, r_i}) ? j_inc + 1'b1 : j_inc;
    assign j_done  = j_next >= {1'b0, r_n};
    assign i_last  = r_i == r_n - 1'b1;
    assign pair_ok = !(i_stat.left && i_stat.right);

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_n      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_drain  <= '0;
            r_have   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_n      <= n_n;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_drain  <= n_drain;
            r_have   <= n_have;
            r_strobe <= n_strobe;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_pend   <= n_pend;
        r_result <= n_result;
    end

    // next state, counters and datapath commands
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_n      = r_n;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_drain  = r_drain;
        n_have   = r_have;
        n_pend   = r_pend;
        n_strobe = 1'b0;
        n_result = r_result;
        o_cmd    = '0;
        o_addr   = r_k[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                o_addr = r_count[AW-1:0];
                if (accept) begin
                    o_cmd.wr_en = room;
                    n_count     = count_after;
                    if (i_final) begin
                        n_count = '0;
                        if (count_after < CNTW'(MIN_POINTS)) begin
                            n_strobe            = 1'b1;
                            n_result.hull_index = '0;
                            n_result.run_end    = 1'b1;
                            n_result.too_few    = 1'b1;
                        end else begin
                            n_n     = count_after;
                            n_i     = '0;
                            n_j     = CNTW'(1);
                            n_have  = 1'b0;
                            n_state = ST_RD_I;
                        end
                    end
                end
            end
            ST_RD_I: begin
                o_addr  = r_i[AW-1:0];
                n_state = ST_RD_J;
            end
            ST_RD_J: begin
                o_addr       = r_j[AW-1:0];
                o_cmd.cap_pi = 1'b1;
                n_state      = ST_LOAD_D;
            end
            ST_LOAD_D: begin
                o_cmd.cap_d = 1'b1;
                n_k         = '0;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                o_addr        = r_k[AW-1:0];
                o_cmd.issue_k = (r_k != r_i) && (r_k != r_j);
                if (r_k == r_n - 1'b1) begin
                    n_drain = DRW'(DRAIN_CYCLES - 1);
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_drain = r_drain - 1'b1;
                end
            end
            ST_DECIDE: begin
                if (!pair_ok && !j_done) begin
                    // try the next partner for the same pivot
                    n_j     = j_next[CNTW-1:0];
                    n_state = ST_RD_I;
                end else begin
                    if (pair_ok) begin
                        // emit the previous hull point, hold this one
                        n_strobe            = r_have;
                        n_result.hull_index = r_pend;
                        n_result.run_end    = 1'b0;
                        n_result.too_few    = 1'b0;
                        n_pend              = IDX_BITS'(r_i);
                        n_have              = 1'b1;
                    end
                    if (i_last) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_j     = '0;
                        n_state = ST_RD_I;
                    end
                end
            end
            ST_FLUSH: begin
                n_strobe            = r_have;
                n_result.hull_index = r_pend;
                n_result.run_end    = 1'b1;
                n_result.too_few    = 1'b0;
                n_have              = 1'b0;
                n_state             = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy   = r_state != ST_IDLE;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // an error result is always the last of its set
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.too_few |-> o_result.run_end)
        else $error("too_few result without run_end");

    // the flush always returns to idle
    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH |=> r_state == ST_IDLE)
        else $error("flush did not return to idle");

    // test points come from inside the stored set
    a_issue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue_k |-> (r_state == ST_SCAN) && (r_k < r_n))
        else $error("point issued outside the set");

    // a point store happens only on an accepted item
    a_write_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> accept && (r_count < CNTW'(MAX_POINTS)))
        else $error("point write without accepted item");

    // the pivot pair is distinct whenever a pair is read
    a_pair_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RD_J |-> r_i != r_j)
        else $error("pivot and partner coincide");

endmodule

// ===== rtl/core/convex_hull_edge_test_marker.sv =====
// Top level of the convex hull edge test marker.
// Joins chm_ctrl and chm_dpath; depends on chm_pkg.
//
//  channel   signals                      direction  transfer
//  points    i_start, o_busy, i_item      in         i_start high and o_busy low
//  results   o_strobe, o_result           out        o_strobe high, one cycle
//
// The final point starts the evaluation: each ordered pair (i, j) sets up the
// edge (ST_RD_I, ST_RD_J, ST_LOAD_D), scans every stored point through the
// single memory read port, drains the cross product pipeline and then decides,
// and a pivot stops at the first partner that makes it a hull point.
// ST_FLUSH then emits the last result.
// o_busy stays high during the evaluation. Results are never held off.
// Reset is synchronous; the point memory needs no clearing pass.
module convex_hull_edge_test_marker
    import chm_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int AW = $clog2(MAX_POINTS);

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [AW-1:0] addr;

    // sequence loading, pair tests and result emission
    chm_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_final  (i_item.final_point),
        .o_busy   (o_busy),
        .o_cmd    (cmd),
        .o_addr   (addr),
        .i_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // store points and run the side test
    chm_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .i_addr  (addr),
        .o_stat  (stat)
    );

endmodule

// ===== verif/convex_hull_edge_test_marker_tb.sv =====
`timescale 1ns / 1ps
// Testbench for convex_hull_edge_test_marker: point sets go in, marked hull indices come out.
// Depends on chm_pkg and the RTL top; a scoreboard class predicts and checks each result.
module convex_hull_edge_test_marker_tb;
    import chm_pkg::*;

    // Track stored points, predict the hull marks of each set, check the results.
    class hull_tracker;
        int        px[DEF_MAX_POINTS];
        int        py[DEF_MAX_POINTS];
        int        count;
        int        mismatches;
        t_out_item marks_due[$];

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        // Store the point; on the final point evaluate the whole set.
        function void add_point(t_in_item it);
            if (count < DEF_MAX_POINTS) begin
                px[count] = int'($signed(it.coord_x));
                py[count] = int'($signed(it.coord_y));
                count++;
            end
            if (it.final_point)
                mark_hull();
        endfunction

        // Sign of the cross product of edge a->b with a->q: -1 left, 1 right, 0 on the line.
        function int side_of_edge(int a, int b, int q);
            longint lhs;
            longint rhs;
            lhs = longint'(py[b] - py[a]) * longint'(px[q] - px[a]);
            rhs = longint'(px[b] - px[a]) * longint'(py[q] - py[a]);
            if (lhs < rhs)
                return -1;
            if (lhs > rhs)
                return 1;
            return 0;
        endfunction

        // Mark both ends of every edge with no points strictly on both sides.
        function void mark_hull();
            bit        on_hull[DEF_MAX_POINTS];
            int        n;
            int        last;
            int        s;
            bit        lft;
            bit        rgt;
            t_out_item r;
            n     = count;
            count = 0;
            if (n < MIN_POINTS) begin
                r.hull_index = '0;
                r.run_end    = 1'b1;
                r.too_few    = 1'b1;
                marks_due = {marks_due, r};
                return;
            end
            foreach (on_hull[i])
                on_hull[i] = 1'b0;
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    if (j == i)
                        continue;
                    lft = 1'b0;
                    rgt = 1'b0;
                    for (int k = 0; k < n && !(lft && rgt); k++) begin
                        if (k == i || k == j)
                            continue;
                        s = side_of_edge(i, j, k);
                        if (s < 0)
                            lft = 1'b1;
                        if (s > 0)
                            rgt = 1'b1;
                    end
                    if (!(lft && rgt)) begin
                        on_hull[i] = 1'b1;
                        on_hull[j] = 1'b1;
                    end
                end
            end
            last = 0;
            for (int i = 0; i < n; i++)
                if (on_hull[i])
                    last = i;
            for (int i = 0; i < n; i++) begin
                if (!on_hull[i])
                    continue;
                r.hull_index = IDX_BITS'(i);
                r.run_end    = (i == last);
                r.too_few    = 1'b0;
                marks_due = {marks_due, r};
            end
        endfunction

        // Print one line per mismatch, cap the output, keep counting.
        task report(string msg);
            if (mismatches < 100)
                $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        // Compare a result with the oldest expected mark.
        task check_mark(t_out_item got);
            t_out_item want;
            if (marks_due.size() == 0) begin
                report($sformatf("unexpected result, index %0d", got.hull_index));
                return;
            end
            want = marks_due.pop_front();
            if (got.hull_index != want.hull_index)
                report($sformatf("hull_index got %0d want %0d", got.hull_index,
                                 want.hull_index));
            if (got.run_end != want.run_end)
                report($sformatf("run_end got %0b want %0b (index %0d)", got.run_end,
                                 want.run_end, want.hull_index));
            if (got.too_few != want.too_few)
                report($sformatf("too_few got %0b want %0b (index %0d)", got.too_few,
                                 want.too_few, want.hull_index));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_start;
    t_in_item    i_item;
    logic        o_busy;
    logic        o_strobe;
    t_out_item   o_result;

    hull_tracker book = new();
    int          items_sent = 0;
    bit          quiet = 1'b0;

    convex_hull_edge_test_marker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check every strobed result at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            book.check_mark(o_result);
    end

    // Offer one point after a random gap; hold it until accepted. Enter and leave at a falling edge.
    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic fin);
        t_in_item it;
        int       gap;
        it.coord_x     = x;
        it.coord_y     = y;
        it.final_point = fin;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do
            @(posedge i_clk);
        while (o_busy);
        book.add_point(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Draw a coordinate: full range with extremes mixed in, or within +/- spread.
    function automatic logic [15:0] pick_coord(int spread);
        if (spread == 0) begin
            case ($urandom_range(0, 7))
                0: return 16'h8000;
                1: return 16'h7fff;
                default: return 16'($urandom);
            endcase
        end
        return 16'(int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Send a set of scattered points.
    task automatic send_cloud(input int n, input int spread);
        for (int i = 0; i < n; i++)
            send_point(pick_coord(spread), pick_coord(spread), i == n - 1);
    endtask

    // Send points that all lie on one line; a zero direction gives coincident points.
    task automatic send_line(input int n);
        int bx;
        int by;
        int dx;
        int dy;
        int t;
        bx = int'($urandom_range(0, 20000)) - 10000;
        by = int'($urandom_range(0, 20000)) - 10000;
        dx = int'($urandom_range(0, 400)) - 200;
        dy = int'($urandom_range(0, 400)) - 200;
        for (int i = 0; i < n; i++) begin
            t = int'($urandom_range(0, 100)) - 50;
            send_point(16'(bx + t * dx), 16'(by + t * dy), i == n - 1);
        end
    endtask

    initial begin
        int set_no;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single point at the range corners: too few
        send_point(16'h8000, 16'h7fff, 1'b1);
        // two points: too few
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b1);
        // square at the extremes of both coordinates
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h7fff, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b1);
        // square with an interior point and a point on an edge
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd10, 16'd0, 1'b0);
        send_point(16'd10, 16'd10, 1'b0);
        send_point(16'd0, 16'd10, 1'b0);
        send_point(16'd5, 16'd5, 1'b0);
        send_point(16'd5, 16'd0, 1'b1);
        // coincident points
        repeat (2) send_point(16'd7, -16'sd7, 1'b0);
        send_point(16'd7, -16'sd7, 1'b1);
        // collinear points
        send_point(-16'sd100, -16'sd50, 1'b0);
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd100, 16'd50, 1'b0);
        send_point(16'h8000, -16'sd16384, 1'b1);

        // random sets; one overfull line drops points, one full cloud runs long
        set_no = 0;
        while (items_sent < 270) begin
            quiet = ($urandom_range(0, 2) == 0);
            if (set_no == 4)
                send_line(DEF_MAX_POINTS + 3);
            else if (set_no == 12)
                send_cloud(DEF_MAX_POINTS, 0);
            else begin
                case ($urandom_range(0, 5))
                    0, 1: send_cloud($urandom_range(3, 9), 0);
                    2:    send_cloud($urandom_range(3, 9), 3);
                    3:    send_line($urandom_range(3, 8));
                    4:    send_cloud($urandom_range(1, 2), 0);
                    default: send_cloud($urandom_range(3, 12), 1000);
                endcase
            end
            set_no++;
        end
        i_start <= 1'b0;

        // drain outstanding marks, then let the pipeline settle
        while (book.marks_due.size() != 0)
            @(posedge i_clk);
        repeat (4 * DRAIN_CYCLES + 8) @(posedge i_clk);
        if (book.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Stop a hung run.
    initial begin
        #16_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
